FILE: rtl/sdp_pkg.sv
// Package for the stereo distance panner.
// Holds the datapath widths, the register index codes and the per-item control struct.
// No dependencies.
package sdp_pkg;

    localparam int POS_W       = 24;
    localparam int DELTA_W     = 25;
    localparam int RVEC_W      = 16;
    localparam int SQ_W        = 50;
    localparam int RES_W       = 51;
    localparam int LEN_W       = 26;
    localparam int NUM_W       = 42;
    localparam int MAG_W       = 41;
    localparam int DIVN_W      = 43;
    localparam int DIVD_W      = 27;
    localparam int QT_W        = 18;
    localparam int DOT_W       = 20;
    localparam int SQRT_STEPS  = 25;
    localparam int ENT_W       = 12;
    localparam int VOL_W       = 8;
    localparam int SCALE_W     = 20;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_ENTITY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X         = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z         = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEGACY_PAN      = 4'd7;

    // Unit right vector along x, Q1.14.
    localparam logic [RVEC_W-1:0] RIGHT_X_RESET = 16'd16384;

    typedef struct packed {
        logic               own;
        logic               found;
        logic [VOL_W-1:0]   master;
        logic [SCALE_W-1:0] scale;
    } t_ctl;

endpackage

FILE: rtl/stereo_distance_panner.sv
// Stereo distance panner: per-channel stereo pan with distance attenuation.
// One item per cycle is accepted while the output is not stalled.
// The 25 square-root steps and the 18 quotient steps, one pipeline stage each, set the depth.
// A stall at the output freezes the whole pipeline; bubbles are not squeezed out.
// Synchronous active-low reset clears all valid bits and loads the register reset values.
// Depends on sdp_pkg.
module stereo_distance_panner
    import sdp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input items
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ENT_W-1:0]             i_source_entity,
    input  logic                         i_origin_found,
    input  logic signed [POS_W-1:0]      i_source_x,
    input  logic signed [POS_W-1:0]      i_source_y,
    input  logic signed [POS_W-1:0]      i_source_z,
    input  logic [VOL_W-1:0]             i_master_volume,
    input  logic [SCALE_W-1:0]           i_distance_scale,
    // result items
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [VOL_W-1:0]             o_left_volume,
    output logic [VOL_W-1:0]             o_right_volume
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond
    // the register list is dropped.
    // ------------------------------------------------------------------
    logic [ENT_W-1:0]         r_listener_entity;
    logic signed [POS_W-1:0]  r_listener_x;
    logic signed [POS_W-1:0]  r_listener_y;
    logic signed [POS_W-1:0]  r_listener_z;
    logic signed [RVEC_W-1:0] r_right_x;
    logic signed [RVEC_W-1:0] r_right_y;
    logic signed [RVEC_W-1:0] r_right_z;
    logic                     r_legacy_pan;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listener_entity <= '0;
            r_listener_x      <= '0;
            r_listener_y      <= '0;
            r_listener_z      <= '0;
            r_right_x         <= RIGHT_X_RESET;
            r_right_y         <= '0;
            r_right_z         <= '0;
            r_legacy_pan      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LISTENER_ENTITY: r_listener_entity <= i_cfg_data[ENT_W-1:0];
                REG_LISTENER_X:      r_listener_x      <= i_cfg_data[POS_W-1:0];
                REG_LISTENER_Y:      r_listener_y      <= i_cfg_data[POS_W-1:0];
                REG_LISTENER_Z:      r_listener_z      <= i_cfg_data[POS_W-1:0];
                REG_RIGHT_X:         r_right_x         <= i_cfg_data[RVEC_W-1:0];
                REG_RIGHT_Y:         r_right_y         <= i_cfg_data[RVEC_W-1:0];
                REG_RIGHT_Z:         r_right_z         <= i_cfg_data[RVEC_W-1:0];
                REG_LEGACY_PAN:      r_legacy_pan      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together unless the finished
    // item in the output register is being held back.
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_out_v;

    assign w_adv   = !(r_out_v && i_stall);
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Stage A: offset from the listener and the special-case flags.
    // ------------------------------------------------------------------
    logic                      r_a_v;
    t_ctl                      r_a_ctl;
    logic signed [DELTA_W-1:0] r_a_dx, r_a_dy, r_a_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_ctl.own    <= (i_source_entity == r_listener_entity);
            r_a_ctl.found  <= i_origin_found;
            r_a_ctl.master <= i_master_volume;
            r_a_ctl.scale  <= i_distance_scale;
            r_a_dx <= DELTA_W'(i_source_x) - DELTA_W'(r_listener_x);
            r_a_dy <= DELTA_W'(i_source_y) - DELTA_W'(r_listener_y);
            r_a_dz <= DELTA_W'(i_source_z) - DELTA_W'(r_listener_z);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squares for the length and products for the projection.
    // ------------------------------------------------------------------
    logic                    r_b_v;
    t_ctl                    r_b_ctl;
    logic [SQ_W-2:0]         r_b_sqx, r_b_sqy, r_b_sqz;
    logic signed [MAG_W-1:0] r_b_px, r_b_py, r_b_pz;
    logic signed [SQ_W-1:0]  w_sqx, w_sqy, w_sqz;
    logic signed [MAG_W-1:0] w_px, w_py, w_pz;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;
    assign w_sqz = r_a_dz * r_a_dz;
    assign w_px  = r_right_x * r_a_dx;
    assign w_py  = r_right_y * r_a_dy;
    assign w_pz  = r_right_z * r_a_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_ctl <= r_a_ctl;
            r_b_sqx <= w_sqx[SQ_W-2:0];
            r_b_sqy <= w_sqy[SQ_W-2:0];
            r_b_sqz <= w_sqz[SQ_W-2:0];
            r_b_px  <= w_px;
            r_b_py  <= w_py;
            r_b_pz  <= w_pz;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: squared length and projection numerator. The numerator
    // enters a side lane that runs beside the root steps.
    // ------------------------------------------------------------------
    logic                    r_sq_v   [0:SQRT_STEPS];
    t_ctl                    r_sq_ctl [0:SQRT_STEPS];
    logic [SQ_W-1:0]         r_sq_n   [0:SQRT_STEPS];
    logic [RES_W-1:0]        r_sq_res [0:SQRT_STEPS];
    logic signed [NUM_W-1:0] r_sq_num [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_ctl[0] <= r_b_ctl;
            r_sq_n[0]   <= SQ_W'(r_b_sqx) + SQ_W'(r_b_sqy) + SQ_W'(r_b_sqz);
            r_sq_res[0] <= '0;
            r_sq_num[0] <= NUM_W'(r_b_px) + NUM_W'(r_b_py) + NUM_W'(r_b_pz);
        end
    end

    // ------------------------------------------------------------------
    // Square root, one result bit per stage, from the top pair of bits
    // of the squared length down to the last.
    // ------------------------------------------------------------------
    genvar gk;
    generate
        for (gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
            localparam logic [RES_W-1:0] STEP_BIT = RES_W'(1) << (2 * (SQRT_STEPS - 1 - gk));
            logic [RES_W-1:0] w_trial;
            logic             w_take;

            assign w_trial = r_sq_res[gk] + STEP_BIT;
            assign w_take  = ({1'b0, r_sq_n[gk]} >= w_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_v[gk+1] <= 1'b0;
                end else if (w_adv) begin
                    r_sq_v[gk+1] <= r_sq_v[gk];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_sq_ctl[gk+1] <= r_sq_ctl[gk];
                    r_sq_num[gk+1] <= r_sq_num[gk];
                    if (w_take) begin
                        r_sq_n[gk+1]   <= r_sq_n[gk] - w_trial[SQ_W-1:0];
                        r_sq_res[gk+1] <= (r_sq_res[gk] >> 1) + STEP_BIT;
                    end else begin
                        r_sq_n[gk+1]   <= r_sq_n[gk];
                        r_sq_res[gk+1] <= r_sq_res[gk] >> 1;
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Divider set-up: the rounded quotient (2|num| + len) / (2 len) is
    // found by restoring division, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic                r_dv_v   [0:QT_W];
    t_ctl                r_dv_ctl [0:QT_W];
    logic [DIVN_W-1:0]   r_dv_rem [0:QT_W];
    logic [DIVD_W-1:0]   r_dv_den [0:QT_W];
    logic [QT_W-1:0]     r_dv_q   [0:QT_W];
    logic [LEN_W-1:0]    r_dv_len [0:QT_W];
    logic                r_dv_neg [0:QT_W];
    logic [LEN_W-1:0]    w_len;
    logic [MAG_W-1:0]    w_mag;
    logic signed [NUM_W-1:0] w_num;

    assign w_len = r_sq_res[SQRT_STEPS][LEN_W-1:0];
    assign w_num = r_sq_num[SQRT_STEPS];
    assign w_mag = w_num[NUM_W-1] ? MAG_W'(-w_num) : MAG_W'(w_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_ctl[0] <= r_sq_ctl[SQRT_STEPS];
            r_dv_rem[0] <= {1'b0, w_mag, 1'b0} + DIVN_W'(w_len);
            r_dv_den[0] <= {w_len, 1'b0};
            r_dv_q[0]   <= '0;
            r_dv_len[0] <= w_len;
            r_dv_neg[0] <= w_num[NUM_W-1];
        end
    end

    generate
        for (gk = 0; gk < QT_W; gk++) begin : g_div
            localparam int SH = QT_W - 1 - gk;
            logic [DIVN_W+1:0] w_dsh;
            logic              w_take;

            assign w_dsh  = (DIVN_W+2)'(r_dv_den[gk]) << SH;
            assign w_take = ({2'b00, r_dv_rem[gk]} >= w_dsh);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[gk+1] <= 1'b0;
                end else if (w_adv) begin
                    r_dv_v[gk+1] <= r_dv_v[gk];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv_ctl[gk+1] <= r_dv_ctl[gk];
                    r_dv_den[gk+1] <= r_dv_den[gk];
                    r_dv_len[gk+1] <= r_dv_len[gk];
                    r_dv_neg[gk+1] <= r_dv_neg[gk];
                    if (w_take) begin
                        r_dv_rem[gk+1] <= r_dv_rem[gk] - w_dsh[DIVN_W-1:0];
                        r_dv_q[gk+1]   <= r_dv_q[gk] | (QT_W'(1) << SH);
                    end else begin
                        r_dv_rem[gk+1] <= r_dv_rem[gk];
                        r_dv_q[gk+1]   <= r_dv_q[gk];
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage E1: signed pan value, forced to zero at zero length or, with
    // legacy panning off, at zero distance scale. The attenuation product
    // length x scale is taken here too.
    // ------------------------------------------------------------------
    logic                    r_e1_v;
    t_ctl                    r_e1_ctl;
    logic signed [DOT_W-1:0] r_e1_dot;
    logic [45:0]             r_e1_prod;
    logic [45:0]             w_prod;
    logic signed [DOT_W-1:0] w_qpos;
    logic                    w_dot_zero;

    assign w_prod     = r_dv_len[QT_W] * r_dv_ctl[QT_W].scale;
    assign w_qpos     = $signed({2'b00, r_dv_q[QT_W]});
    assign w_dot_zero = (r_dv_len[QT_W] == '0)
                     || ((r_dv_ctl[QT_W].scale == '0) && !r_legacy_pan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (w_adv) begin
            r_e1_v <= r_dv_v[QT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1_ctl  <= r_dv_ctl[QT_W];
            r_e1_prod <= w_prod;
            if (w_dot_zero) begin
                r_e1_dot <= '0;
            end else if (r_dv_neg[QT_W]) begin
                r_e1_dot <= -w_qpos;
            end else begin
                r_e1_dot <= w_qpos;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E2: attenuation factor (1 - d) in Q.28 and the two pan
    // factors (1 -/+ dot) in Q.14.
    // ------------------------------------------------------------------
    logic                    r_e2_v;
    t_ctl                    r_e2_ctl;
    logic signed [46:0]      r_e2_att;
    logic signed [DOT_W-1:0] r_e2_bl, r_e2_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (w_adv) begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e2_ctl <= r_e1_ctl;
            r_e2_att <= 47'sd268435456 - $signed({1'b0, r_e1_prod});
            r_e2_bl  <= 20'sd16384 - r_e1_dot;
            r_e2_br  <= 20'sd16384 + r_e1_dot;
        end
    end

    // ------------------------------------------------------------------
    // Stage E3: magnitudes and signs; master volume times pan factor.
    // ------------------------------------------------------------------
    logic              r_e3_v;
    t_ctl              r_e3_ctl;
    logic [45:0]       r_e3_ma;
    logic [26:0]       r_e3_m1l, r_e3_m1r;
    logic              r_e3_negl, r_e3_negr;
    logic [18:0]       w_mbl, w_mbr;
    logic [26:0]       w_m1l, w_m1r;

    assign w_mbl = r_e2_bl[DOT_W-1] ? 19'(-r_e2_bl) : 19'(r_e2_bl);
    assign w_mbr = r_e2_br[DOT_W-1] ? 19'(-r_e2_br) : 19'(r_e2_br);
    assign w_m1l = r_e2_ctl.master * w_mbl;
    assign w_m1r = r_e2_ctl.master * w_mbr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_v <= 1'b0;
        end else if (w_adv) begin
            r_e3_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e3_ctl  <= r_e2_ctl;
            r_e3_ma   <= r_e2_att[46] ? 46'(-r_e2_att) : 46'(r_e2_att);
            r_e3_m1l  <= w_m1l;
            r_e3_m1r  <= w_m1r;
            r_e3_negl <= r_e2_att[46] != r_e2_bl[DOT_W-1];
            r_e3_negr <= r_e2_att[46] != r_e2_br[DOT_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage E4: the wide product split into two partial products per channel.
    // ------------------------------------------------------------------
    logic        r_e4_v;
    t_ctl        r_e4_ctl;
    logic [49:0] r_e4_pll, r_e4_phl, r_e4_plr, r_e4_phr;
    logic        r_e4_negl, r_e4_negr;
    logic [49:0] w_pll, w_phl, w_plr, w_phr;

    assign w_pll = r_e3_m1l * r_e3_ma[22:0];
    assign w_phl = r_e3_m1l * r_e3_ma[45:23];
    assign w_plr = r_e3_m1r * r_e3_ma[22:0];
    assign w_phr = r_e3_m1r * r_e3_ma[45:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_v <= 1'b0;
        end else if (w_adv) begin
            r_e4_v <= r_e3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e4_ctl  <= r_e3_ctl;
            r_e4_pll  <= w_pll;
            r_e4_phl  <= w_phl;
            r_e4_plr  <= w_plr;
            r_e4_phr  <= w_phr;
            r_e4_negl <= r_e3_negl;
            r_e4_negr <= r_e3_negr;
        end
    end

    // ------------------------------------------------------------------
    // Stage E5 (output register): Q.42 product rounded half away from
    // zero and saturated, then the listener and unknown-origin cases.
    // ------------------------------------------------------------------
    function automatic logic [VOL_W-1:0] f_round_sat(input logic [72:0] total,
                                                     input logic        neg);
        logic [72:0] rnd;
        rnd = (total + (73'd1 << 41)) >> 42;
        if (neg) begin
            return '0;
        end else if (total >= (73'd511 << 41)) begin
            return '1;
        end
        return rnd[VOL_W-1:0];
    endfunction

    logic [VOL_W-1:0] r_out_left, r_out_right;
    logic [72:0]      w_tot_l, w_tot_r;
    logic [VOL_W-1:0] n_left, n_right;

    assign w_tot_l = {r_e4_phl, 23'b0} + 73'(r_e4_pll);
    assign w_tot_r = {r_e4_phr, 23'b0} + 73'(r_e4_plr);

    always_comb begin
        if (r_e4_ctl.own) begin
            n_left  = r_e4_ctl.master;
            n_right = r_e4_ctl.master;
        end else if (!r_e4_ctl.found) begin
            n_left  = '0;
            n_right = '0;
        end else begin
            n_left  = f_round_sat(w_tot_l, r_e4_negl);
            n_right = f_round_sat(w_tot_r, r_e4_negr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_e4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_left  <= n_left;
            r_out_right <= n_right;
        end
    end

    assign o_valid        = r_out_v;
    assign o_left_volume  = r_out_left;
    assign o_right_volume = r_out_right;

endmodule

FILE: rtl/sdp_checker.sv
// Port-level checks for the stereo distance panner.
// Bound to stereo_distance_panner; uses the widths from sdp_pkg.
module sdp_checker
    import sdp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_cfg_ready,
    input logic [VOL_W-1:0] o_left_volume,
    input logic [VOL_W-1:0] o_right_volume
);

    // A held result keeps its value until it is taken.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_left_volume)
                                  && $stable(o_right_volume)))
        else $error("result changed while stalled");

    // The input side is only held back by a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind stereo_distance_panner sdp_checker u_sdp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_cfg_ready    (o_cfg_ready),
    .o_left_volume  (o_left_volume),
    .o_right_volume (o_right_volume)
);
